FILE: src/usbtmc_header_deframer_unit_defines.svh
// assertion macros used by the deframer top level
`ifndef USBTMC_HEADER_DEFRAMER_UNIT_DEFINES_SVH
`define USBTMC_HEADER_DEFRAMER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// property checked on every clock edge outside reset
`define UHD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define UHD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define UHD_ASSERT(lbl, clk, rst, prop, msg)
`define UHD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: src/usbtmc_hdr_pkg.sv
// types and constants of the usbtmc bulk-in header deframer
package usbtmc_hdr_pkg;

  localparam int COUNT_W = 17;
  localparam int SIZE_W  = 32;

  // frame header layout
  localparam logic [COUNT_W-1:0] HEADER_BYTES  = 17'd12;
  localparam logic [COUNT_W-1:0] IDX_MSG_ID    = 17'd0;
  localparam logic [COUNT_W-1:0] IDX_TAG       = 17'd1;
  localparam logic [COUNT_W-1:0] IDX_TAG_INV   = 17'd2;
  localparam logic [COUNT_W-1:0] IDX_SIZE_B0   = 17'd4;
  localparam logic [COUNT_W-1:0] IDX_SIZE_B1   = 17'd5;
  localparam logic [COUNT_W-1:0] IDX_SIZE_B2   = 17'd6;
  localparam logic [COUNT_W-1:0] IDX_SIZE_B3   = 17'd7;
  localparam logic [COUNT_W-1:0] IDX_ATTR      = 17'd8;
  localparam logic [COUNT_W-1:0] IDX_HDR_LAST  = 17'd11;

  localparam logic [7:0] MSG_DEV_DEP_IN = 8'h02;
  localparam logic [7:0] EOM_MASK       = 8'h01;

  localparam logic [COUNT_W-1:0] CAPACITY_RESET = 17'd4096;

  // command codes
  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic              payload_valid;
    logic [7:0]        payload_byte;
    logic              payload_last;
    logic              frame_done;
    logic [7:0]        msg_id;
    logic [7:0]        tag;
    logic              tag_mismatch;
    logic [SIZE_W-1:0] transfer_size;
    logic              eom;
    logic              unsupported_msg;
    logic              overflow;
  } out_item_t;

  // registered input item handed to the parser
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

endpackage

FILE: src/usbtmc_hdr_in_reg.sv
// input register stage with stall generation
module usbtmc_hdr_in_reg (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  usbtmc_hdr_pkg::in_item_t in_data,
  input  logic                     take,
  output usbtmc_hdr_pkg::stage_t   stage
);
  import usbtmc_hdr_pkg::*;

  logic     valid;
  in_item_t item;

  // stalled only while holding an item that cannot move on
  assign in_stall = valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  // payload capture on transfer
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

FILE: src/usbtmc_hdr_parse.sv
// frame state and header parsing logic
module usbtmc_hdr_parse (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic [16:0]               cfg_data,
  input  usbtmc_hdr_pkg::stage_t    stage,
  input  logic                      take,
  output usbtmc_hdr_pkg::out_item_t result
);
  import usbtmc_hdr_pkg::*;

  logic [COUNT_W-1:0] capacity_bytes;
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]         header_id, header_id_next;
  logic [7:0]         header_tag, header_tag_next;
  logic [7:0]         header_tag_inv, header_tag_inv_next;
  logic [SIZE_W-1:0]  size_field, size_field_next;
  logic               eom_flag, eom_flag_next;
  logic               done_flag, done_flag_next;
  logic               attr_bit, attr_bit_next;

  logic               advance;
  logic               header_done;
  logic [SIZE_W:0]    frame_end;
  logic [SIZE_W:0]    idx_ext;
  logic [7:0]         b;

  assign advance = stage.valid && take;
  assign b       = stage.item.data_byte;
  assign idx_ext = {{(SIZE_W + 1 - COUNT_W){1'b0}}, byte_count};

  // next state and result for the item in the input register
  always_comb begin
    byte_count_next     = byte_count;
    header_id_next      = header_id;
    header_tag_next     = header_tag;
    header_tag_inv_next = header_tag_inv;
    size_field_next     = size_field;
    eom_flag_next       = eom_flag;
    done_flag_next      = done_flag;
    attr_bit_next       = attr_bit;
    result              = '0;
    frame_end           = '0;

    if (stage.item.cmd == CMD_CLEAR) begin
      byte_count_next     = '0;
      header_id_next      = '0;
      header_tag_next     = '0;
      header_tag_inv_next = '0;
      size_field_next     = '0;
      eom_flag_next       = 1'b1;
      done_flag_next      = 1'b0;
      attr_bit_next       = 1'b0;
    end else if (byte_count >= capacity_bytes) begin
      result.overflow = 1'b1;
    end else begin
      result.accepted = 1'b1;
      byte_count_next = byte_count + 17'd1;

      // header field capture by byte position
      unique case (byte_count)
        IDX_MSG_ID:  header_id_next           = b;
        IDX_TAG:     header_tag_next          = b;
        IDX_TAG_INV: header_tag_inv_next      = b;
        IDX_SIZE_B0: size_field_next[7:0]     = b;
        IDX_SIZE_B1: size_field_next[15:8]    = b;
        IDX_SIZE_B2: size_field_next[23:16]   = b;
        IDX_SIZE_B3: size_field_next[31:24]   = b;
        IDX_ATTR:    attr_bit_next            = |(b & EOM_MASK);
        default:     ;
      endcase

      if (byte_count == IDX_HDR_LAST && header_id == MSG_DEV_DEP_IN) begin
        eom_flag_next = attr_bit;
      end

      // payload window and frame end
      frame_end = {{(SIZE_W + 1 - COUNT_W){1'b0}}, HEADER_BYTES} + {1'b0, size_field_next};
      if (byte_count_next >= HEADER_BYTES) begin
        if (byte_count >= HEADER_BYTES && idx_ext < frame_end) begin
          result.payload_valid = 1'b1;
          result.payload_byte  = b;
          result.payload_last  = (idx_ext + 33'd1) == frame_end;
        end
        if ({{(SIZE_W + 1 - COUNT_W){1'b0}}, byte_count_next} >= frame_end) begin
          done_flag_next = 1'b1;
        end
      end
    end

    // status seen after this item
    header_done            = byte_count_next >= HEADER_BYTES;
    result.frame_done      = done_flag_next;
    result.msg_id          = header_id_next;
    result.tag             = header_tag_next;
    result.tag_mismatch    = header_done && (header_tag_inv_next != ~header_tag_next);
    result.transfer_size   = size_field_next;
    result.eom             = eom_flag_next;
    result.unsupported_msg = header_done && (header_id_next != MSG_DEV_DEP_IN);
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      header_id      <= '0;
      header_tag     <= '0;
      header_tag_inv <= '0;
      size_field     <= '0;
      eom_flag       <= 1'b1;
      done_flag      <= 1'b0;
      attr_bit       <= 1'b0;
    end else if (advance) begin
      byte_count     <= byte_count_next;
      header_id      <= header_id_next;
      header_tag     <= header_tag_next;
      header_tag_inv <= header_tag_inv_next;
      size_field     <= size_field_next;
      eom_flag       <= eom_flag_next;
      done_flag      <= done_flag_next;
      attr_bit       <= attr_bit_next;
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_bytes <= CAPACITY_RESET;
    end else if (cfg_valid) begin
      capacity_bytes <= cfg_data;
    end
  end

endmodule

FILE: src/usbtmc_hdr_out_reg.sv
// result register toward the downstream channel
module usbtmc_hdr_out_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load_valid,
  input  usbtmc_hdr_pkg::out_item_t load_data,
  output logic                      take,
  output logic                      out_valid,
  input  logic                      out_stall,
  output usbtmc_hdr_pkg::out_item_t out_data
);
  import usbtmc_hdr_pkg::*;

  // room when empty or when the held result leaves this cycle
  assign take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && load_valid) begin
      out_data <= load_data;
    end
  end

endmodule

FILE: src/usbtmc_header_deframer_unit.sv
// top level of the usbtmc bulk-in header deframer
//
// Input channel: in_valid, in_stall, in_data (cmd, data_byte). A byte or a
// clear command transfers on a clock edge with in_valid high and in_stall low.
// Output channel: out_valid, out_stall, out_data; one result per input item,
// in order, transferred on an edge with out_valid high and out_stall low.
// Config channel: cfg_valid, cfg_ready (always high), cfg_data writes the
// 17-bit frame capacity; write it only while no item is in flight.
// An input transfer passes the input register, then the result register,
// before out_valid rises. Throughput is one item per cycle while out_stall
// is low, with the parse combinational between the two registers, since the
// frame state for the next byte is ready right after the current one.
// When out_stall is high and a result is held, the input register keeps its
// item and in_stall rises; once a slot frees, flow resumes with nothing lost.
// Reset (rst, synchronous) empties both registers, clears the frame state
// (eom reads 1) and sets the capacity to 4096 bytes.
module usbtmc_header_deframer_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  usbtmc_hdr_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output usbtmc_hdr_pkg::out_item_t out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [16:0]               cfg_data
);
  import usbtmc_hdr_pkg::*;

`include "usbtmc_header_deframer_unit_defines.svh"

  stage_t    stage;
  out_item_t result;
  logic      take;

  assign cfg_ready = 1'b1;

  usbtmc_hdr_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .take     (take),
    .stage    (stage)
  );

  usbtmc_hdr_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .stage     (stage),
    .take      (take),
    .result    (result)
  );

  usbtmc_hdr_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (stage.valid),
    .load_data  (result),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // refused byte is never counted as stored
  `UHD_ASSERT(a_ovf_not_acc, clk, rst, out_valid |-> !(out_data.overflow && out_data.accepted), "overflow result also marked accepted")
  // last mark only on a payload byte, payload only from a stored byte, and frame_done matching the last mark
  `UHD_ASSERT(a_last_is_payload, clk, rst, (out_valid && out_data.payload_last) |-> out_data.payload_valid, "payload_last without payload_valid")
  `UHD_ASSERT(a_payload_acc, clk, rst, (out_valid && out_data.payload_valid) |-> (out_data.accepted && out_data.frame_done == out_data.payload_last), "payload byte not stored or frame_done out of step")
  // a held item with room downstream must move on
  `UHD_ASSERT(a_no_false_stall, clk, rst, (!out_valid && stage.valid) |-> !in_stall, "input stalled with empty result register")

endmodule

FILE: dv/usbtmc_header_deframer_unit_test.sv
// self-checking testbench of the usbtmc bulk-in header deframer
module usbtmc_header_deframer_unit_test;
  import usbtmc_hdr_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_data = '0;

  usbtmc_header_deframer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // byte stream waiting to be sent and results predicted for accepted transfers
  in_item_t  tx_items[$];
  out_item_t predicted_results[$];

  int bytes_queued = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int overflows_seen = 0;
  int payload_lasts_seen = 0;
  int frames_done_seen = 0;

  int   tx_gap = 0;
  int   rx_wait = 0;
  int   rx_wait_next;
  logic tx_quiet = 1'b0;
  logic rx_quiet = 1'b0;
  logic hold_off = 1'b0;
  out_item_t want_res;

  // deframer state as the predictor sees it
  logic [COUNT_W-1:0] capacity_m = CAPACITY_RESET;
  logic [COUNT_W-1:0] count_m;
  logic [7:0]         id_m;
  logic [7:0]         tag_m;
  logic [7:0]         tag_inv_m;
  logic [SIZE_W-1:0]  size_m;
  logic               eom_m;
  logic               done_m;
  logic               attr_m;

  function automatic void clear_frame();
    count_m = '0;
    id_m = '0;
    tag_m = '0;
    tag_inv_m = '0;
    size_m = '0;
    eom_m = 1'b1;
    done_m = 1'b0;
    attr_m = 1'b0;
  endfunction

  // advance the frame state by one transfer and return the expected result
  function automatic out_item_t deframe_step(in_item_t it);
    out_item_t          r;
    logic [COUNT_W-1:0] idx;
    logic [33:0]        frame_end;
    r = '0;
    if (it.cmd == CMD_CLEAR) begin
      clear_frame();
    end else if (count_m >= capacity_m) begin
      r.overflow = 1'b1;
    end else begin
      idx = count_m;
      r.accepted = 1'b1;
      count_m = count_m + 17'd1;
      case (idx)
        IDX_MSG_ID:  id_m = it.data_byte;
        IDX_TAG:     tag_m = it.data_byte;
        IDX_TAG_INV: tag_inv_m = it.data_byte;
        IDX_SIZE_B0: size_m[7:0] = size_m[7:0] | it.data_byte;
        IDX_SIZE_B1: size_m[15:8] = size_m[15:8] | it.data_byte;
        IDX_SIZE_B2: size_m[23:16] = size_m[23:16] | it.data_byte;
        IDX_SIZE_B3: size_m[31:24] = size_m[31:24] | it.data_byte;
        IDX_ATTR:    attr_m = (it.data_byte & EOM_MASK) != 8'd0;
        default: ;
      endcase
      if (idx == IDX_HDR_LAST && id_m == MSG_DEV_DEP_IN) eom_m = attr_m;
      if (count_m >= HEADER_BYTES) begin
        frame_end = 34'(HEADER_BYTES) + 34'(size_m);
        if (idx >= HEADER_BYTES && 34'(idx) < frame_end) begin
          r.payload_valid = 1'b1;
          r.payload_byte = it.data_byte;
          r.payload_last = (34'(idx) + 34'd1 == frame_end);
        end
        if (34'(count_m) >= frame_end) done_m = 1'b1;
      end
    end
    r.frame_done = done_m;
    r.msg_id = id_m;
    r.tag = tag_m;
    r.tag_mismatch = (count_m >= HEADER_BYTES) && (tag_inv_m != ~tag_m);
    r.transfer_size = size_m;
    r.eom = eom_m;
    r.unsupported_msg = (count_m >= HEADER_BYTES) && (id_m != MSG_DEV_DEP_IN);
    return r;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at result %0d: %s", results_checked, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // sender: takes queued bytes, idles a drawn number of cycles between transfers
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_results.push_back(deframe_step(in_data));
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (tx_items.size() != 0) begin
          in_data <= tx_items.pop_front();
          in_valid <= 1'b1;
          tx_gap <= tx_quiet ? 0 : $urandom_range(0, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result transfer, then stalls a drawn number of cycles
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          report("result with nothing predicted");
        end else begin
          want_res = predicted_results.pop_front();
          check_field("accepted", 32'(out_data.accepted), 32'(want_res.accepted));
          check_field("payload_valid", 32'(out_data.payload_valid),
                      32'(want_res.payload_valid));
          check_field("payload_byte", 32'(out_data.payload_byte),
                      32'(want_res.payload_byte));
          check_field("payload_last", 32'(out_data.payload_last),
                      32'(want_res.payload_last));
          check_field("frame_done", 32'(out_data.frame_done), 32'(want_res.frame_done));
          check_field("msg_id", 32'(out_data.msg_id), 32'(want_res.msg_id));
          check_field("tag", 32'(out_data.tag), 32'(want_res.tag));
          check_field("tag_mismatch", 32'(out_data.tag_mismatch),
                      32'(want_res.tag_mismatch));
          check_field("transfer_size", out_data.transfer_size, want_res.transfer_size);
          check_field("eom", 32'(out_data.eom), 32'(want_res.eom));
          check_field("unsupported_msg", 32'(out_data.unsupported_msg),
                      32'(want_res.unsupported_msg));
          check_field("overflow", 32'(out_data.overflow), 32'(want_res.overflow));
        end
        results_checked++;
        if (out_data.overflow) overflows_seen++;
        if (out_data.payload_last) payload_lasts_seen++;
        if (out_data.frame_done) frames_done_seen++;
        rx_wait_next = rx_quiet ? 0 : $urandom_range(0, 14);
      end else if (rx_wait != 0) begin
        rx_wait_next = rx_wait - 1;
      end else begin
        rx_wait_next = 0;
      end
      rx_wait <= rx_wait_next;
      out_stall <= hold_off || (rx_wait_next != 0);
    end
  end

  // long receiver hold-offs while the sender keeps offering bytes
  initial begin
    wait (bytes_sent >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (100) @(posedge clk);
    hold_off <= 1'b0;
    wait (bytes_sent >= 850);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (120) @(posedge clk);
    hold_off <= 1'b0;
  end

  // run limit
  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

  task automatic push_item(input logic cmd, input logic [7:0] b);
    in_item_t it;
    it.cmd = cmd;
    it.data_byte = b;
    tx_items.push_back(it);
    bytes_queued++;
  endtask

  // header of twelve bytes, payload bytes, then alignment bytes
  task automatic add_frame(input logic [7:0] id, input logic [7:0] tg,
                           input logic [7:0] tg_inv, input logic [31:0] size,
                           input logic [7:0] attr, input int n_payload, input int n_align);
    push_item(CMD_DATA, id);
    push_item(CMD_DATA, tg);
    push_item(CMD_DATA, tg_inv);
    push_item(CMD_DATA, 8'($urandom));
    push_item(CMD_DATA, size[7:0]);
    push_item(CMD_DATA, size[15:8]);
    push_item(CMD_DATA, size[23:16]);
    push_item(CMD_DATA, size[31:24]);
    push_item(CMD_DATA, attr);
    repeat (3) push_item(CMD_DATA, 8'($urandom));
    repeat (n_payload) push_item(CMD_DATA, 8'($urandom));
    repeat (n_align) push_item(CMD_DATA, 8'($urandom));
  endtask

  // mostly well-formed frames with random content, some broken or noisy
  task automatic add_random_frame();
    logic [7:0]  id;
    logic [7:0]  tg;
    logic [7:0]  tg_inv;
    logic [31:0] size;
    int          pick;
    int          n_payload;
    if ($urandom_range(0, 14) == 0) begin
      push_item(CMD_CLEAR, 8'($urandom));
      repeat ($urandom_range(1, 11)) push_item($urandom_range(0, 7) == 0, 8'($urandom));
      return;
    end
    if ($urandom_range(0, 6) != 0) push_item(CMD_CLEAR, 8'($urandom));
    id = ($urandom_range(0, 4) != 0) ? MSG_DEV_DEP_IN : 8'($urandom);
    tg = 8'($urandom);
    tg_inv = ($urandom_range(0, 6) != 0) ? ~tg : 8'($urandom);
    pick = $urandom_range(0, 19);
    if (pick < 14) size = $urandom_range(0, 24);
    else if (pick < 16) size = 0;
    else size = $urandom;
    if (size <= 24) n_payload = (pick % 5 == 0) ? $urandom_range(0, size + 4) : size;
    else n_payload = $urandom_range(0, 8);
    add_frame(id, tg, tg_inv, size, 8'($urandom), n_payload, $urandom_range(0, 3));
  endtask

  // wait until every queued byte has been sent and every result checked
  task automatic drain();
    do @(negedge clk);
    while (tx_items.size() != 0 || in_valid || predicted_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [16:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    capacity_m = value;
    @(negedge clk);
  endtask

  // stimulus
  logic [16:0] capacity_plan[6];
  int          phase_target;

  initial begin
    clear_frame();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: dev-dep frame with two payload bytes and eom clear
    add_frame(MSG_DEV_DEP_IN, 8'h00, 8'hff, 32'd2, 8'h00, 2, 1);
    push_item(CMD_CLEAR, 8'hff);
    drain();

    // directed: unsupported id, tag mismatch, maximum size, capacity reached
    write_capacity(17'd13);
    add_frame(8'hff, 8'hff, 8'hff, 32'hffff_ffff, 8'hff, 1, 1);
    push_item(CMD_CLEAR, 8'h00);
    drain();

    capacity_plan[0] = 17'd65536;
    capacity_plan[1] = 17'd13;
    capacity_plan[2] = 17'($urandom_range(14, 48));
    capacity_plan[3] = 17'($urandom_range(13, 65536));
    capacity_plan[4] = CAPACITY_RESET;
    capacity_plan[5] = 17'($urandom_range(13, 300));
    foreach (capacity_plan[p]) begin
      write_capacity(capacity_plan[p]);
      tx_quiet <= ($urandom_range(0, 3) == 0);
      rx_quiet <= ($urandom_range(0, 3) == 0);
      phase_target = bytes_queued + 205;
      while (bytes_queued < phase_target) add_random_frame();
      drain();
    end

    repeat (10) @(posedge clk);
    if (predicted_results.size() != 0)
      report($sformatf("%0d predicted results never arrived", predicted_results.size()));
    $display("covered %0d byte and clear transfers over capacities 13 to 65536",
             bytes_sent);
    $display("%0d results checked, %0d overflows, %0d last payload bytes, %0d done",
             results_checked, overflows_seen, payload_lasts_seen, frames_done_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
